>>> src/ordered_list_insert_store_core_macros.svh
// assertion macros shared by the ordered list insert store
`ifndef ORDERED_LIST_INSERT_STORE_CORE_MACROS_SVH
`define ORDERED_LIST_INSERT_STORE_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define OLS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered list store check failed");

// next-cycle implication, clocked on clk, off during reset
`define OLS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list store check failed");

`endif

>>> src/ols_pkg.sv
// shared types and constants for the ordered list insert store
package ols_pkg;

    localparam int DEPTH  = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = 6;
    localparam int VAL_W  = 32;
    localparam int MODE_W = 3;
    localparam int POS_W  = 6;
    localparam int STAT_W = 2;

    localparam logic [MODE_W-1:0] MODE_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POS   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_COUNT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic rd_step;
    } ols_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              count_zero;
        logic              rd_last;
    } ols_stat_t;

endpackage

>>> src/ols_ctrl.sv
// control state machine for the ordered list insert store
module ols_ctrl
    import ols_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  ols_stat_t stat,
    output ols_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.load_in = 1'b0;
        cmd.exec    = 1'b0;
        cmd.rd_step = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.mode == MODE_READ && !stat.count_zero)
                    state_next = S_READ;
                else
                    state_next = S_IDLE;
            end
            S_READ:
            begin
                cmd.rd_step = 1'b1;
                if (stat.rd_last)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> src/ols_datapath.sv
// shifting cell store, count and result registers
module ols_datapath
    import ols_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ols_cmd_t                 cmd,
    output ols_stat_t                stat,
    input  logic [MODE_W-1:0]        mode,
    input  logic signed [VAL_W-1:0]  value,
    input  logic [POS_W-1:0]         position,
    output logic                     done,
    output logic signed [VAL_W-1:0]  element,
    output logic [CNT_W-1:0]         count,
    output logic [STAT_W-1:0]        status,
    output logic                     last
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [MODE_W-1:0]  mode_reg;
    logic [VAL_W-1:0]   value_reg;
    logic [POS_W-1:0]   position_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   rd_idx_next;
    logic [VAL_W-1:0]   cell_reg  [DEPTH];
    logic [VAL_W-1:0]   cell_next [DEPTH];

    logic               done_reg;
    logic               done_next;
    logic [VAL_W-1:0]   element_reg;
    logic [VAL_W-1:0]   element_next;
    logic [CNT_W-1:0]   count_out_reg;
    logic [CNT_W-1:0]   count_out_next;
    logic [STAT_W-1:0]  status_reg;
    logic [STAT_W-1:0]  status_next;
    logic               last_reg;
    logic               last_next;

    logic               is_ins;
    logic               full;
    logic               range_bad;
    logic               do_ins;
    logic [CNT_W-1:0]   at;
    logic               rd_last;

    always_comb
    begin
        is_ins    = mode_reg inside {MODE_FRONT, MODE_BACK, MODE_POS};
        full      = (count_reg == FULL_CNT);
        range_bad = (mode_reg == MODE_POS) &&
                    ((position_reg == '0) || (CNT_W'(position_reg) > count_reg));
        do_ins    = cmd.exec && is_ins && !range_bad && !full;
        case (mode_reg)
            MODE_FRONT: at = '0;
            MODE_BACK:  at = count_reg;
            default:    at = CNT_W'(position_reg);
        endcase
        rd_last   = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);
    end

    // open a gap at slot at and drop the value in
    always_comb
    begin
        cell_next[0] = cell_reg[0];
        if (do_ins && at == '0)
            cell_next[0] = value_reg;
        for (int i = 1; i < DEPTH; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (do_ins)
            begin
                if (CNT_W'(i) == at)
                    cell_next[i] = value_reg;
                else if (CNT_W'(i) > at && CNT_W'(i) <= count_reg)
                    cell_next[i] = cell_reg[i-1];
            end
        end
    end

    always_comb
    begin
        count_next     = count_reg + CNT_W'(do_ins);
        rd_idx_next    = rd_idx_reg;
        done_next      = 1'b0;
        element_next   = '0;
        count_out_next = count_next;
        status_next    = STAT_OK;
        last_next      = 1'b1;
        if (cmd.exec)
        begin
            rd_idx_next = '0;
            if (is_ins || mode_reg == MODE_COUNT ||
                (mode_reg == MODE_READ && count_reg == '0))
                done_next = 1'b1;
            if (range_bad)
                status_next = STAT_RANGE;
            else if (is_ins && full)
                status_next = STAT_FULL;
            else if (mode_reg == MODE_READ)
                status_next = STAT_EMPTY;
        end
        else if (cmd.rd_step)
        begin
            rd_idx_next  = rd_idx_reg + IDX_W'(1);
            done_next    = 1'b1;
            element_next = cell_reg[rd_idx_reg];
            last_next    = rd_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_idx_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg     <= mode;
            value_reg    <= value;
            position_reg <= position;
        end
        for (int i = 0; i < DEPTH; i++)
            cell_reg[i] <= cell_next[i];
        element_reg   <= element_next;
        count_out_reg <= count_out_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

    assign stat.mode       = mode_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.rd_last    = rd_last;

    assign done    = done_reg;
    assign element = element_reg;
    assign count   = count_out_reg;
    assign status  = status_reg;
    assign last    = last_reg;

endmodule

>>> src/ordered_list_insert_store_core.sv
// top level of the ordered list insert store
//
// Keeps an ordered list of up to DEPTH (32) signed 32-bit values in a row
// of shifting cells, starting empty. An item is taken when start is high
// and busy is low. Modes: 0 insert at front, 1 insert at back, 2 insert
// after the first 'position' elements (valid for 1 to count), 3 report the
// count, 4 read out the list. Modes 5 to 7 give no result and change
// nothing. Every result is shown for one cycle with done high and cannot
// be held off; count is the count after the operation, last marks the
// final result of the item. Inserts and count run in two steps: capture
// of the item, then one in which the result register loads and, for an
// insert, the cells above the slot shift up one place at once. A readout
// runs as the capture step, a check step, then one cell a cycle through
// the single read port of the cell row. An empty readout gives one
// result with status empty. Results are registered, so a new item may be
// started in the same cycle as the previous result shows. Cells hold
// nothing meaningful until written; only cells below count are ever read.
`include "ordered_list_insert_store_core_macros.svh"

module ordered_list_insert_store_core
    import ols_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [MODE_W-1:0]        mode,
    input  logic signed [VAL_W-1:0]  value,
    input  logic [POS_W-1:0]         position,
    output logic                     done,
    output logic signed [VAL_W-1:0]  element,
    output logic [CNT_W-1:0]         count,
    output logic [STAT_W-1:0]        status,
    output logic                     last
);

    // command and status between controller and datapath
    ols_cmd_t  cmd;
    ols_stat_t stat;

    // sequencing: idle, execute, then for a readout one read step per stored element
    ols_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // cells, count and the result registers
    ols_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .mode     (mode),
        .value    (value),
        .position (position),
        .done     (done),
        .element  (element),
        .count    (count),
        .status   (status),
        .last     (last)
    );

    // an accepted item always occupies the block for the next cycle
    `OLS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // the count never exceeds the cell row
    `OLS_ASSERT_NOW(a_count_bound, done, count <= CNT_W'(DEPTH))
    // any error or empty report is a single, final result
    `OLS_ASSERT_NOW(a_err_last, done && status != STAT_OK, last)
    // readout results come back to back until the last one
    `OLS_ASSERT_NEXT(a_read_burst, done && !last, done)

endmodule
